// ===== design/pngse_pkg.sv =====
// shared constants, types and helper functions of the png stored-deflate encoder
package pngse_pkg;

  localparam int MAX_DIMENSION = 256;
  localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
  localparam int PROD_W        = 2 * DIM_W + 3;
  localparam int MAX_TOTAL     = MAX_DIMENSION * (1 + 4 * MAX_DIMENSION);
  localparam int TOTAL_W       = $clog2(MAX_TOTAL + 1);
  localparam int BLOCK_MAX     = 65535;
  localparam int MAX_BLOCKS    = (MAX_TOTAL + BLOCK_MAX - 1) / BLOCK_MAX;
  localparam int BLK_W         = $clog2(MAX_BLOCKS + 1);
  localparam int ADLER_MOD     = 65521;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_SEED = 32'hffffffff;

  localparam logic [63:0] PNG_SIG  = 64'h89504e470d0a1a0a;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454e44;
  localparam logic [7:0]  ZLIB_CMF = 8'h78;
  localparam logic [7:0]  ZLIB_FLG = 8'h01;

  // last step index of each sequencer phase
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] HDR_LAST   = 6'd42;
  localparam logic [IDX_W-1:0] BLK_LAST   = 6'd4;
  localparam logic [IDX_W-1:0] TRAIL_LAST = 6'd19;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified input word handed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic        hdr;
    logic        bfinal;
    logic [15:0] piece;
    logic        last;
    logic [31:0] adler;
  } item_t;

  // image geometry as seen by the back end
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      idat_len;
  } img_size_t;

  // one byte through the reflected crc-32 register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big-endian byte pick, sel 0 is the most significant byte
  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] sel);
    return 8'(w >> {~sel, 3'b000});
  endfunction

endpackage

// ===== design/png_stored_deflate_encoder_core.sv =====
// top level of the rgba8 png encoder with stored deflate blocks
//
//  channel | dir | width | contents
//  in_     | in  | 8     | tdata: data_byte
//  out_    | out | 8+1+1 | tdata: out_byte, tuser: last_of_item, tlast: end_of_file
//  cfg_    | in  | 1+9   | index 0 image_width, index 1 image_height
//
// one input word per cycle while out_tready is high and no header, block or trailer
// bytes go out; each word becomes 1 output byte, plus 43 header bytes on the first word
// of an image, 5 at each stored-block start and 20 after the last word; the output port
// delivers one byte a cycle while out_tready is high, and the 2-word queue buffers input.
// synchronous reset and a config write hold in_tready low while the size pipeline settles.
module png_stored_deflate_encoder_core
  import pngse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tuser,  // [0] last_of_item
  output logic                 out_tlast
);

  logic      q_ready, q_push, q_valid, q_pop;
  item_t     push_entry, head;
  img_size_t img_size;

  pngse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (push_entry),
    .img_size  (img_size)
  );

  pngse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head)
  );

  pngse_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (head),
    .q_pop         (q_pop),
    .img_size      (img_size),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_byte      (out_tdata),
    .out_last_item (out_tuser),
    .out_eof       (out_tlast)
  );

  // end of file is always the last byte of its word
  a_eof_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end of file without last_of_item");

  // no push into a full queue
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("queue overflow");

  // input held off while derived sizes settle after a config write
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input taken right after config write");

  // nothing popped from an empty queue
  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue underflow");

endmodule

// ===== design/pngse_front.sv =====
// front end: config registers, size derivation, per-word block and adler bookkeeping
module pngse_front
  import pngse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 q_ready,
  output logic                 q_push,
  output item_t                q_entry,
  output img_size_t            img_size
);

  logic [CFG_W-1:0]   width_cfg_r, height_cfg_r;
  logic [1:0]         settle_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [TOTAL_W-1:0] total_r;
  logic [31:0]        idat_len_r;

  logic [DIM_W-1:0]   w_c, h_c;
  logic [DIM_W+2:0]   row_len;
  logic [PROD_W-1:0]  prod;
  logic [BLK_W-1:0]   blocks;

  logic [TOTAL_W-1:0] dc_r, dc_nxt;
  logic [15:0]        br_r, br_nxt;
  logic [15:0]        adl_low_r, adl_low_nxt;
  logic [15:0]        adl_high_r, adl_high_nxt;

  logic [TOTAL_W-1:0] left;
  logic [15:0]        piece;
  logic               need_hdr, is_last, accept;
  logic [16:0]        low_sum, high_sum;
  logic [15:0]        low_m, high_m;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > MAX_DIMENSION) return DIM_W'(MAX_DIMENSION);
    return DIM_W'(v);
  endfunction

  assign w_c     = clamp_dim(width_cfg_r);
  assign h_c     = clamp_dim(height_cfg_r);
  assign row_len = {w_c, 2'b00} + (DIM_W + 3)'(1);
  assign prod    = PROD_W'(h_c) * PROD_W'(row_len);

  // stored blocks needed: count of block boundaries below the total
  always_comb begin
    blocks = '0;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (32'(total_r) > k * BLOCK_MAX) blocks = blocks + BLK_W'(1);
    end
  end

  assign in_tready = q_ready && (settle_r == 2'd0);
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  assign need_hdr = (br_r == 16'd0);
  assign left     = (total_r > dc_r) ? (total_r - dc_r) : TOTAL_W'(1);
  assign piece    = (32'(left) < BLOCK_MAX) ? 16'(left) : 16'(BLOCK_MAX);
  assign is_last  = (32'(dc_r) + 32'd1) >= 32'(total_r);

  assign low_sum  = {1'b0, adl_low_r} + 17'(in_tdata);
  assign low_m    = (low_sum >= 17'(ADLER_MOD)) ? 16'(low_sum - 17'(ADLER_MOD)) : low_sum[15:0];
  assign high_sum = {1'b0, adl_high_r} + {1'b0, low_m};
  assign high_m   = (high_sum >= 17'(ADLER_MOD)) ? 16'(high_sum - 17'(ADLER_MOD))
                                                 : high_sum[15:0];

  always_comb begin
    q_entry.data_byte = in_tdata;
    q_entry.first     = (dc_r == '0);
    q_entry.hdr       = need_hdr;
    q_entry.bfinal    = (32'(left) <= BLOCK_MAX);
    q_entry.piece     = piece;
    q_entry.last      = is_last;
    q_entry.adler     = {high_m, low_m};

    dc_nxt       = dc_r;
    br_nxt       = br_r;
    adl_low_nxt  = adl_low_r;
    adl_high_nxt = adl_high_r;
    if (accept) begin
      if (is_last) begin
        dc_nxt       = '0;
        br_nxt       = '0;
        adl_low_nxt  = 16'd1;
        adl_high_nxt = '0;
      end else begin
        dc_nxt       = dc_r + TOTAL_W'(1);
        br_nxt       = (need_hdr ? piece : br_r) - 16'd1;
        adl_low_nxt  = low_m;
        adl_high_nxt = high_m;
      end
    end
  end

  assign img_size.width    = width_r;
  assign img_size.height   = height_r;
  assign img_size.idat_len = idat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= CFG_W'(1);
      height_cfg_r <= CFG_W'(1);
      settle_r     <= 2'd2;
      dc_r         <= '0;
      br_r         <= '0;
      adl_low_r    <= 16'd1;
      adl_high_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH)  width_cfg_r  <= cfg_wdata;
        if (cfg_index == REG_HEIGHT) height_cfg_r <= cfg_wdata;
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
      dc_r       <= dc_nxt;
      br_r       <= br_nxt;
      adl_low_r  <= adl_low_nxt;
      adl_high_r <= adl_high_nxt;
    end
  end

  // size pipeline: clamp and multiply, then block count and idat length
  always_ff @(posedge clk) begin
    width_r    <= w_c;
    height_r   <= h_c;
    total_r    <= prod[TOTAL_W-1:0];
    idat_len_r <= 32'(total_r) + 32'(blocks) * 32'd5 + 32'd6;
  end

endmodule

// ===== design/pngse_queue.sv =====
// short queue of classified words between front and back
module pngse_queue
  import pngse_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_entry,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign ready = (32'(count_r) < QUEUE_DEPTH);
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

// ===== design/pngse_back.sv =====
// back end: byte sequencer for headers, block headers, data and trailer, with crc
module pngse_back
  import pngse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  item_t     q_entry,
  output logic      q_pop,
  input  img_size_t img_size,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_byte,
  output logic      out_last_item,
  output logic      out_eof
);

  typedef enum logic [1:0] {PH_HEAD, PH_BLK, PH_DATA, PH_TRAIL} phase_t;

  phase_t           phase_r, phase_nxt, start_phase;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             cur_v_r, cur_v_nxt;
  item_t            cur_r, cur_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_eof_r, out_eof_nxt;

  logic [7:0]  emit;
  logic        upd, rst_crc, fin_ph, fin_item, eof, adv, step, load;
  logic [31:0] crc_base, crc_new;
  logic [31:0] w_word, h_word;

  assign w_word = 32'(img_size.width);
  assign h_word = 32'(img_size.height);

  // byte selection for the current step
  always_comb begin
    emit    = '0;
    upd     = 1'b0;
    rst_crc = 1'b0;
    fin_ph  = 1'b0;
    unique case (phase_r)
      PH_HEAD: begin
        fin_ph = (idx_r == HDR_LAST);
        case (idx_r) inside
          [6'd0:6'd7]:   emit = 8'(PNG_SIG >> {~idx_r[2:0], 3'b000});
          [6'd8:6'd11]:  emit = byte_of(32'd13, idx_r[1:0]);
          [6'd12:6'd15]: begin
            emit = byte_of(TAG_IHDR, idx_r[1:0]); upd = 1'b1;
            rst_crc = (idx_r == 6'd12);
          end
          [6'd16:6'd19]: begin emit = byte_of(w_word, idx_r[1:0]); upd = 1'b1; end
          [6'd20:6'd23]: begin emit = byte_of(h_word, idx_r[1:0]); upd = 1'b1; end
          6'd24:         begin emit = 8'd8; upd = 1'b1; end   // bit depth
          6'd25:         begin emit = 8'd6; upd = 1'b1; end   // color type rgba
          [6'd26:6'd28]: begin emit = 8'd0; upd = 1'b1; end
          [6'd29:6'd32]: emit = byte_of(~crc_r, 2'(idx_r - 6'd29));
          [6'd33:6'd36]: emit = byte_of(img_size.idat_len, 2'(idx_r - 6'd33));
          [6'd37:6'd40]: begin
            emit = byte_of(TAG_IDAT, 2'(idx_r - 6'd37)); upd = 1'b1;
            rst_crc = (idx_r == 6'd37);
          end
          6'd41:         begin emit = ZLIB_CMF; upd = 1'b1; end
          default:       begin emit = ZLIB_FLG; upd = 1'b1; end
        endcase
      end
      PH_BLK: begin
        fin_ph = (idx_r == BLK_LAST);
        upd    = 1'b1;
        case (idx_r[2:0])
          3'd0:    emit = {7'd0, cur_r.bfinal};
          3'd1:    emit = cur_r.piece[7:0];
          3'd2:    emit = cur_r.piece[15:8];
          3'd3:    emit = ~cur_r.piece[7:0];
          default: emit = ~cur_r.piece[15:8];
        endcase
      end
      PH_DATA: begin
        fin_ph = 1'b1;
        upd    = 1'b1;
        emit   = cur_r.data_byte;
      end
      PH_TRAIL: begin
        fin_ph = (idx_r == TRAIL_LAST);
        case (idx_r) inside
          [6'd0:6'd3]:   begin emit = byte_of(cur_r.adler, idx_r[1:0]); upd = 1'b1; end
          [6'd4:6'd7]:   emit = byte_of(~crc_r, idx_r[1:0]);
          [6'd8:6'd11]:  emit = 8'd0;
          [6'd12:6'd15]: begin
            emit = byte_of(TAG_IEND, idx_r[1:0]); upd = 1'b1;
            rst_crc = (idx_r == 6'd12);
          end
          default:       emit = byte_of(~crc_r, idx_r[1:0]);
        endcase
      end
      default: emit = '0;
    endcase
  end

  assign crc_base = rst_crc ? CRC_SEED : crc_r;
  assign crc_new  = crc_byte(crc_base, emit);
  assign fin_item = fin_ph && ((phase_r == PH_TRAIL) || (phase_r == PH_DATA && !cur_r.last));
  assign eof      = fin_ph && (phase_r == PH_TRAIL);

  assign adv   = !out_valid_r || out_tready;
  assign step  = cur_v_r && adv;
  assign load  = q_valid && (!cur_v_r || (step && fin_item));
  assign q_pop = load;

  always_comb begin
    if (q_entry.first)    start_phase = PH_HEAD;
    else if (q_entry.hdr) start_phase = PH_BLK;
    else                  start_phase = PH_DATA;
  end

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    cur_v_nxt     = cur_v_r;
    cur_nxt       = cur_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_eof_nxt   = out_eof_r;

    if (step) begin
      if (upd) crc_nxt = crc_new;
      if (fin_ph) begin
        idx_nxt = '0;
        unique case (phase_r)
          PH_HEAD:  phase_nxt = cur_r.hdr ? PH_BLK : PH_DATA;
          PH_BLK:   phase_nxt = PH_DATA;
          PH_DATA:  phase_nxt = PH_TRAIL;
          PH_TRAIL: phase_nxt = PH_TRAIL;
          default:  phase_nxt = PH_DATA;
        endcase
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (fin_item) cur_v_nxt = 1'b0;
    end

    if (load) begin
      cur_nxt   = q_entry;
      cur_v_nxt = 1'b1;
      phase_nxt = start_phase;
      idx_nxt   = '0;
    end

    if (adv) begin
      out_valid_nxt = cur_v_r;
      out_byte_nxt  = emit;
      out_last_nxt  = fin_item;
      out_eof_nxt   = eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      idx_r       <= '0;
      cur_v_r     <= 1'b0;
      cur_r       <= '0;
      crc_r       <= CRC_SEED;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      out_last_r  <= 1'b0;
      out_eof_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      cur_v_r     <= cur_v_nxt;
      cur_r       <= cur_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      out_byte_r  <= out_byte_nxt;
      out_last_r  <= out_last_nxt;
      out_eof_r   <= out_eof_nxt;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_item = out_last_r;
  assign out_eof       = out_eof_r;

endmodule

// ===== sim/png_stored_deflate_encoder_core_tb.sv =====
// testbench for the png stored-deflate encoder core: random stream stimulus with a byte-exact file predictor
module png_stored_deflate_encoder_core_tb;
  import pngse_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 380;

  typedef struct {
    logic [7:0] value;
    logic       item_end;
    logic       file_end;
  } png_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  png_stored_deflate_encoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // stimulus and expectation stores
  logic [7:0]  scanline_q[$];
  png_byte_t   png_bytes_q[$];
  logic [7:0]  step_bytes[$];
  int unsigned bytes_pushed = 0;
  int          mismatches = 0;
  int          out_index = 0;
  int          quiet_cycles = 0;
  bit          no_gaps = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          tx_gap = 0;
  int          rx_pause = 0;

  // encoder state as the block should hold it
  logic [8:0]  size_w = 9'd1;
  logic [8:0]  size_h = 9'd1;
  int unsigned data_taken = 0;
  int unsigned blk_left = 0;
  int unsigned adl_lo = 1;
  int unsigned adl_hi = 0;
  logic [31:0] crc_run = CRC_SEED;

  function automatic int unsigned clamp_dim(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  function automatic int unsigned frame_total(input logic [8:0] w, input logic [8:0] h);
    return clamp_dim(h) * (1 + 4 * clamp_dim(w));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic emit(input logic [7:0] b);
    step_bytes.push_back(b);
  endtask

  task automatic emit_crc(input logic [7:0] b);
    logic [31:0] c;
    c = crc_run ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    crc_run = c;
    emit(b);
  endtask

  // big-endian, optionally through the chunk crc
  task automatic emit_word(input logic [31:0] v, input bit with_crc);
    for (int s = 3; s >= 0; s--) begin
      if (with_crc) emit_crc(v[8*s +: 8]);
      else emit(v[8*s +: 8]);
    end
  endtask

  task automatic encode_scanline_byte(input logic [7:0] data);
    int unsigned w, h, total, blocks, left, piece;
    logic [15:0] inv;
    bit file_done;
    png_byte_t pb;
    w = clamp_dim(size_w);
    h = clamp_dim(size_h);
    total = h * (1 + 4 * w);
    step_bytes.delete();
    if (data_taken == 0) begin
      blocks = (total + BLOCK_MAX - 1) / BLOCK_MAX;
      for (int i = 0; i < 8; i++) emit(PNG_SIG[63 - 8*i -: 8]);
      emit_word(32'd13, 1'b0);
      crc_run = CRC_SEED;
      emit_word(TAG_IHDR, 1'b1);
      emit_word(w, 1'b1);
      emit_word(h, 1'b1);
      emit_crc(8'd8);
      emit_crc(8'd6);
      emit_crc(8'd0);
      emit_crc(8'd0);
      emit_crc(8'd0);
      emit_word(crc_run ^ CRC_SEED, 1'b0);
      emit_word(2 + total + 5 * blocks + 4, 1'b0);
      crc_run = CRC_SEED;
      emit_word(TAG_IDAT, 1'b1);
      emit_crc(ZLIB_CMF);
      emit_crc(ZLIB_FLG);
    end
    if (blk_left == 0) begin
      // a shrunk size mid-image leaves a one-byte final block
      left = (total > data_taken) ? total - data_taken : 1;
      piece = (left < BLOCK_MAX) ? left : BLOCK_MAX;
      inv = 16'(piece) ^ 16'hffff;
      emit_crc((left <= BLOCK_MAX) ? 8'd1 : 8'd0);
      emit_crc(8'(piece));
      emit_crc(8'(piece >> 8));
      emit_crc(inv[7:0]);
      emit_crc(inv[15:8]);
      blk_left = piece;
    end
    emit_crc(data);
    adl_lo = adl_lo + data;
    if (adl_lo >= ADLER_MOD) adl_lo = adl_lo - ADLER_MOD;
    adl_hi = adl_hi + adl_lo;
    if (adl_hi >= ADLER_MOD) adl_hi = adl_hi - ADLER_MOD;
    blk_left = (blk_left - 1) & 32'hffff;
    data_taken++;
    file_done = (data_taken >= total);
    if (file_done) begin
      emit_word({adl_hi[15:0], adl_lo[15:0]}, 1'b1);
      emit_word(crc_run ^ CRC_SEED, 1'b0);
      emit_word(32'd0, 1'b0);
      crc_run = CRC_SEED;
      emit_word(TAG_IEND, 1'b1);
      emit_word(crc_run ^ CRC_SEED, 1'b0);
      data_taken = 0;
      blk_left = 0;
      adl_lo = 1;
      adl_hi = 0;
      crc_run = CRC_SEED;
    end
    foreach (step_bytes[i]) begin
      pb.value = step_bytes[i];
      pb.item_end = (i == step_bytes.size() - 1);
      pb.file_end = file_done && pb.item_end;
      png_bytes_q.push_back(pb);
    end
  endtask

  // driver: one word from the queue per handshake, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'd0;
      tx_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (scanline_q.size() > 0) begin
        in_tdata <= scanline_q.pop_front();
        in_tvalid <= 1'b1;
        tx_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver side stalls, with one long hold-off while the sender keeps going
  always @(posedge clk) begin : rx_side
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_pause <= 0;
      hold_taken <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      rx_pause <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_pause > 0) begin
      rx_pause <= rx_pause - 1;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_pause <= g - 1;
      end
    end
  end

  // monitor: predicts on accepted input words, checks accepted output words
  always @(posedge clk) begin : monitor
    png_byte_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) encode_scanline_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (png_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word %0d: %02h last_of_item %0b end_of_file %0b",
                     out_index, out_tdata, out_tuser, out_tlast);
        end else begin
          e = png_bytes_q.pop_front();
          if (out_tdata !== e.value || out_tuser !== e.item_end || out_tlast !== e.file_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output word %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       out_index, e.value, e.item_end, e.file_end,
                       out_tdata, out_tuser, out_tlast);
          end
        end
        out_index++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (scanline_q.size() != 0 || in_tvalid || png_bytes_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_WIDTH) size_w = val;
    else size_h = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input logic [8:0] w, input logic [8:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic push_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) scanline_q.push_back(8'($urandom_range(0, 255)));
    bytes_pushed += n;
  endtask

  // part of an image, then a size change while the block is idle, then the rest
  task automatic image_with_resize(input logic [8:0] w0, input logic [8:0] h0,
                                   input logic [8:0] w1, input logic [8:0] h1);
    int unsigned t0, t1, k;
    set_size(w0, h0);
    t0 = frame_total(w0, h0);
    k = $urandom_range(1, t0 - 1);
    push_random(k);
    set_size(w1, h1);
    t1 = frame_total(w1, h1);
    push_random((t1 > k) ? t1 - k : 1);
  endtask

  function automatic logic [8:0] pick_dim(input int hi);
    if ($urandom_range(0, 9) == 0) return 9'd0;
    return 9'($urandom_range(1, hi));
  endfunction

  initial begin : stimulus
    int unsigned start_count, n;
    int grp;
    logic [8:0] w, h;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset size, byte extremes
    scanline_q.push_back(8'h00);
    scanline_q.push_back(8'hff);
    scanline_q.push_back(8'hff);
    scanline_q.push_back(8'h80);
    scanline_q.push_back(8'h01);
    bytes_pushed += 5;
    // size shrunk below the bytes taken, then grown mid-image
    set_size(9'd2, 9'd1);
    push_random(6);
    set_size(9'd1, 9'd1);
    push_random(1);
    push_random(3);
    write_reg(REG_HEIGHT, 9'd2);
    push_random(7);

    // random images, mostly small
    grp = 0;
    start_count = bytes_pushed;
    while (bytes_pushed - start_count < RANDOM_ITEMS) begin
      if (grp == 0) begin
        no_gaps = 1'b0;
        set_size(9'd4, 9'd3);
        push_random(2 * frame_total(9'd4, 9'd3));
        long_hold_req = 1'b1;
      end else begin
        no_gaps = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0) begin
          image_with_resize(pick_dim(4), pick_dim(3), pick_dim(4), pick_dim(3));
        end else begin
          w = pick_dim(4);
          h = pick_dim(3);
          set_size(w, h);
          n = $urandom_range(1, 3);
          push_random(n * frame_total(w, h));
        end
      end
      grp++;
    end
    no_gaps = 1'b0;

    // clamped sizes at both ends of the register range, each image cut short by a shrink
    set_size(9'd511, 9'd0);
    push_random(7);
    set_size(9'd1, 9'd1);
    push_random(1);
    set_size(9'd0, 9'd300);
    push_random(9);
    set_size(9'd1, 9'd1);
    push_random(1);

    // several stored blocks announced, the first one not final
    set_size(9'd256, 9'd256);
    push_random(12);
    set_size(9'd1, 9'd1);
    push_random(1);

    // grown until the block runs out, then shrunk: a one-byte final block ends the image
    push_random(3);
    write_reg(REG_HEIGHT, 9'd2);
    push_random(2);
    write_reg(REG_HEIGHT, 9'd1);
    push_random(1);

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && png_bytes_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== png_stored_deflate_encoder_core.f =====
design/pngse_pkg.sv
design/pngse_front.sv
design/pngse_queue.sv
design/pngse_back.sv
design/png_stored_deflate_encoder_core.sv
sim/png_stored_deflate_encoder_core_tb.sv
